// File: hw/rtl/lspv_pkg.sv
// Package for the looping sample player voice.
// Holds stream layout widths, register indexes, opcodes and the sequencer state type.
// No dependencies.
`default_nettype none

package lspv_pkg;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned ADDR_W      = 17;
  localparam int unsigned STORE_DEPTH = 131072;
  localparam int unsigned CFG_DATA_W  = 17;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned IN_DATA_W   = 104;
  localparam int unsigned OUT_DATA_W  = 56;
  localparam int unsigned DIV_STEPS   = 33;

  localparam logic [16:0] MAX_FRAMES = 17'd65536;
  localparam logic [16:0] FRAC_ONE   = 17'd65536;
  localparam logic [32:0] PH_LIMIT   = 33'h1_0000_FFFF;

  localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL_FRAMES  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOOP_ON       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PLAY_ON       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_REGION_START  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_REGION_END    = 3'd5;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_REGION = 13'b0000000000010,
    ST_BOUND  = 13'b0000000000100,
    ST_NEXT   = 13'b0000000001000,
    ST_READ0  = 13'b0000000010000,
    ST_READ1  = 13'b0000000100000,
    ST_LERP   = 13'b0000001000000,
    ST_GAIN   = 13'b0000010000000,
    ST_MIX    = 13'b0000100000000,
    ST_DIV    = 13'b0001000000000,
    ST_DFIX   = 13'b0010000000000,
    ST_DADD   = 13'b0100000000000,
    ST_DONE   = 13'b1000000000000
  } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/looping_sample_player_voice.sv
// Looping sample player voice: sample store, playhead, interpolation, gain and mix.
// Depends on lspv_pkg.
//
// Channel   Direction  Handshake                     Content
// s_axis    in         s_axis_tvalid/s_axis_tready   load or render beat
// m_axis    out        m_axis_tvalid/m_axis_tready   mixed frame and playhead
// cfg       in         cfg_valid/cfg_ready           register index and data
//
// A load beat writes the store in the cycle it is accepted.
// A render beat runs REGION, BOUND, NEXT, READ0, READ1, LERP, GAIN, MIX, DONE
// to the result register, a read-modify sequence around the two-port sample store;
// a full-remainder loop wrap adds DIV, DFIX, DADD of the bit-serial remainder unit.
// A new beat is accepted while a result waits in the output register.
// Reset is synchronous and restores the register defaults and a zero playhead.
`default_nettype none

module looping_sample_player_voice (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // load_address, load_value, trigger, speed, gain, mix_in_left, mix_in_right
  input  wire logic [lspv_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // opcode
  input  wire logic                            s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // out_left, out_right, playhead_frame, sounding
  output logic [lspv_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [lspv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [lspv_pkg::CFG_DATA_W-1:0] cfg_data
);

  import lspv_pkg::*;

  state_t state;

  logic [16:0] total_frames;
  logic [1:0]  channel_count;
  logic        loop_on;
  logic        play_on;
  logic [16:0] region_start_frac;
  logic [16:0] region_end_frac;
  logic [32:0] playhead;

  logic [16:0] frames;
  logic [16:0] start_frac_c;
  logic [16:0] end_frac_c;
  logic [16:0] cfg_frames_c;
  logic [33:0] cfg_start_prod;
  logic [32:0] tq;
  logic        cc2;
  logic        in_fire;
  logic        cfg_fire;
  logic        store_we;

  logic               trig;
  logic signed [19:0] spd;
  logic signed [15:0] gain;
  logic signed [15:0] mix_l;
  logic signed [15:0] mix_r;

  logic signed [15:0] store [STORE_DEPTH];
  logic [ADDR_W-1:0]  rd_addr_a;
  logic [ADDR_W-1:0]  rd_addr_b;
  logic signed [15:0] rd_a;
  logic signed [15:0] rd_b;
  logic               rd_ch;

  logic [33:0] start_prod;
  logic [33:0] end_prod;
  logic [32:0] rs;
  logic [32:0] re0;
  logic [32:0] re_min;
  logic [33:0] re;
  logic [33:0] len;
  logic [32:0] ph_cur;
  logic        active;
  logic        in_range;
  logic [17:0] nx_a;
  logic [17:0] nx_b;
  logic [17:0] nx_c;
  logic [15:0] nx;
  logic signed [34:0] spd_ext;
  logic signed [34:0] ph_sum;
  logic signed [35:0] ph_sum36;
  logic signed [35:0] re36;
  logic signed [35:0] rs36;
  logic signed [35:0] len36;
  logic signed [35:0] d;
  logic signed [35:0] dl;
  logic signed [35:0] dp;
  logic               oor;
  logic [33:0]        r;
  logic               need_div;
  logic [32:0]        ph_fast;
  logic [32:0]        ph_new;

  logic signed [15:0] s0_l;
  logic signed [15:0] s1_l;
  logic signed [16:0] diff_l;
  logic signed [16:0] diff_r;
  logic signed [16:0] frac_s;
  logic signed [33:0] lerp_l;
  logic signed [33:0] lerp_r;
  logic signed [32:0] v_l;
  logic signed [32:0] v_r;
  logic signed [48:0] p_l;
  logic signed [48:0] p_r;
  logic signed [49:0] rnd_l;
  logic signed [49:0] rnd_r;
  logic signed [19:0] sum_l;
  logic signed [19:0] sum_r;
  logic signed [15:0] res_l;
  logic signed [15:0] res_r;
  logic               sounding;

  logic [33:0] rem;
  logic [33:0] rem_sh;
  logic [32:0] dmag;
  logic [5:0]  div_cnt;
  logic        d_neg;

  function automatic logic signed [15:0] sat16(input logic signed [19:0] x);
    logic signed [15:0] y;
    if (x > 20'sd32767) begin
      y = 16'sh7FFF;
    end else if (x < -20'sd32768) begin
      y = 16'sh8000;
    end else begin
      y = x[15:0];
    end
    return y;
  endfunction

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign cfg_fire      = cfg_valid & cfg_ready;
  assign store_we      = in_fire && (s_axis_tuser == OP_LOAD);

  assign frames       = (total_frames > MAX_FRAMES) ? MAX_FRAMES : total_frames;
  assign start_frac_c = (region_start_frac > FRAC_ONE) ? FRAC_ONE : region_start_frac;
  assign end_frac_c   = (region_end_frac > FRAC_ONE) ? FRAC_ONE : region_end_frac;
  assign cfg_frames_c = (cfg_data > MAX_FRAMES) ? MAX_FRAMES : cfg_data;
  assign cfg_start_prod = start_frac_c * cfg_frames_c;
  assign tq  = {frames, 16'd0};
  assign cc2 = channel_count[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      total_frames      <= '0;
      channel_count     <= 2'd1;
      loop_on           <= 1'b1;
      play_on           <= 1'b1;
      region_start_frac <= '0;
      region_end_frac   <= FRAC_ONE;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        CFG_TOTAL_FRAMES:  total_frames      <= cfg_data;
        CFG_CHANNEL_COUNT: channel_count     <= cfg_data[1:0];
        CFG_LOOP_ON:       loop_on           <= cfg_data[0];
        CFG_PLAY_ON:       play_on           <= cfg_data[0];
        CFG_REGION_START:  region_start_frac <= cfg_data;
        CFG_REGION_END:    region_end_frac   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      trig  <= s_axis_tdata[33];
      spd   <= s_axis_tdata[53:34];
      gain  <= s_axis_tdata[69:54];
      mix_l <= s_axis_tdata[85:70];
      mix_r <= s_axis_tdata[101:86];
    end
  end

  assign rd_ch     = (state == ST_READ1) && cc2;
  assign rd_addr_a = cc2 ? {ph_cur[31:16], rd_ch} : {1'b0, ph_cur[31:16]};
  assign rd_addr_b = cc2 ? {nx, rd_ch} : {1'b0, nx};

  always_ff @(posedge clk) begin
    if (store_we) begin
      store[s_axis_tdata[16:0]] <= s_axis_tdata[32:17];
    end
    rd_a <= store[rd_addr_a];
    rd_b <= store[rd_addr_b];
  end

  assign start_prod = start_frac_c * frames;
  assign end_prod   = end_frac_c * frames;
  assign re_min     = (re0 > tq) ? tq : re0;
  assign nx_a       = {1'b0, ph_cur[32:16]} + 18'd1;
  assign nx_b       = (loop_on && (nx_a >= re[33:16])) ? {1'b0, rs[32:16]} : nx_a;
  assign nx_c       = (nx_b >= {1'b0, frames}) ? ({1'b0, frames} - 18'd1) : nx_b;
  assign spd_ext    = {{15{spd[19]}}, spd};
  assign ph_sum36   = {ph_sum[34], ph_sum};
  assign re36       = $signed({2'b00, re});
  assign rs36       = $signed({3'b000, rs});
  assign len36      = $signed({2'b00, len});

  assign frac_s = $signed({1'b0, ph_cur[15:0]});
  assign diff_l = $signed({s1_l[15], s1_l}) - $signed({s0_l[15], s0_l});
  assign diff_r = $signed({rd_b[15], rd_b}) - $signed({rd_a[15], rd_a});
  assign lerp_l = $signed({s0_l, 16'd0}) + diff_l * frac_s;
  assign lerp_r = $signed({rd_a, 16'd0}) + diff_r * frac_s;

  assign rnd_l = {p_l[48], p_l} + 50'sd536870912;
  assign rnd_r = {p_r[48], p_r} + 50'sd536870912;
  assign sum_l = {{4{mix_l[15]}}, mix_l} + rnd_l[49:30];
  assign sum_r = {{4{mix_r[15]}}, mix_r} + rnd_r[49:30];

  assign rem_sh = {rem[32:0], dmag[32]};

  always_ff @(posedge clk) begin
    unique case (state)
      ST_REGION: begin
        rs  <= start_prod[32:0];
        re0 <= end_prod[32:0];
      end
      ST_BOUND: begin
        re     <= (re_min <= rs) ? ({1'b0, rs} + 34'd65536) : {1'b0, re_min};
        ph_cur <= trig ? rs : playhead;
        active <= (frames != 17'd0) && play_on;
      end
      ST_NEXT: begin
        in_range <= (ph_cur[32:16] < frames);
        nx       <= nx_c[15:0];
        len      <= re - {1'b0, rs};
        ph_sum   <= $signed({2'b00, ph_cur}) + spd_ext;
      end
      ST_READ0: begin
        d   <= ph_sum36 - rs36;
        oor <= (ph_sum36 >= re36) || (ph_sum36 < rs36);
      end
      ST_READ1: begin
        s0_l <= rd_a;
        s1_l <= rd_b;
        dl   <= d - len36;
        dp   <= d + len36;
      end
      ST_LERP: begin
        v_l <= lerp_l[32:0];
        v_r <= lerp_r[32:0];
        if (!loop_on) begin
          if (ph_sum < 35'sd0) begin
            ph_fast <= '0;
          end else if (ph_sum > $signed({2'b00, tq})) begin
            ph_fast <= tq;
          end else begin
            ph_fast <= ph_sum[32:0];
          end
        end else begin
          ph_fast <= ph_sum[32:0];
        end
        need_div <= 1'b0;
        if (!dl[35] && (dl < len36)) begin
          r <= dl[33:0];
        end else if (d[35] && !dp[35]) begin
          r <= dp[33:0];
        end else begin
          r        <= '0;
          need_div <= loop_on && oor && active;
        end
      end
      ST_GAIN: begin
        p_l <= v_l * gain;
        p_r <= v_r * gain;
        if (!active) begin
          ph_new <= ph_cur;
        end else if (loop_on && oor) begin
          ph_new <= rs + r[32:0];
        end else begin
          ph_new <= ph_fast;
        end
        dmag    <= d[35] ? 33'(-d) : d[32:0];
        d_neg   <= d[35];
        rem     <= '0;
        div_cnt <= '0;
      end
      ST_MIX: begin
        sounding <= active && in_range;
        res_l    <= (active && in_range) ? sat16(sum_l) : mix_l;
        res_r    <= (active && in_range) ? sat16(sum_r) : mix_r;
      end
      ST_DIV: begin
        rem     <= (rem_sh >= len) ? (rem_sh - len) : rem_sh;
        dmag    <= {dmag[31:0], 1'b0};
        div_cnt <= div_cnt + 6'd1;
      end
      ST_DFIX: begin
        r <= (d_neg && (rem != 34'd0)) ? (len - rem) : rem;
      end
      ST_DADD: begin
        ph_new <= rs + r[32:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      playhead      <= '0;
    end else begin
      if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_fire && (cfg_index == CFG_TOTAL_FRAMES)) begin
        playhead <= cfg_start_prod[32:0];
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire && (s_axis_tuser == OP_RENDER)) begin
            state <= ST_REGION;
          end
        end
        ST_REGION: state <= ST_BOUND;
        ST_BOUND:  state <= ST_NEXT;
        ST_NEXT:   state <= ST_READ0;
        ST_READ0:  state <= ST_READ1;
        ST_READ1:  state <= ST_LERP;
        ST_LERP:   state <= ST_GAIN;
        ST_GAIN:   state <= ST_MIX;
        ST_MIX:    state <= need_div ? ST_DIV : ST_DONE;
        ST_DIV: begin
          if (div_cnt == 6'(DIV_STEPS - 1)) begin
            state <= ST_DFIX;
          end
        end
        ST_DFIX:   state <= ST_DADD;
        ST_DADD:   state <= ST_DONE;
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {6'd0, sounding, ph_new[32:16], res_r, res_l};
            playhead      <= ph_new;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_render_starts: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (s_axis_tuser == OP_RENDER)) |=> (state == ST_REGION))
    else $error("render beat did not start the sequence");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (div_cnt < 6'(DIV_STEPS)))
    else $error("remainder unit ran past its step count");

  a_playhead_range: assert property (@(posedge clk) disable iff (rst)
    playhead <= PH_LIMIT)
    else $error("playhead beyond the largest region end");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    store_we |=> (state == ST_IDLE))
    else $error("load beat left the sequencer busy");

endmodule

`default_nettype wire
